[rtl/core/rxmb_pkg.sv]
// Package for the receive mailbox timestamp sorter.
// Holds the function codes, field widths and the sequencer state type.
`default_nettype none
package rxmb_pkg;
    localparam int unsigned MBOX_BITS  = 6;
    localparam int unsigned KEY_BITS   = 17;
    localparam int unsigned COUNT_BITS = 7;
    localparam int unsigned FUNC_BITS  = 2;
    localparam int unsigned IN_TIME_BITS = 16;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_START = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;
endpackage
`default_nettype wire

[rtl/core/rxmb_if.sv]
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface rxmb_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/rxmb_ram.sv]
// Generic single-port-write, one-read synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module rxmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[rtl/core/rx_mailbox_timestamp_order.sv]
// Top level of the receive mailbox timestamp sorter.
// Depends on rxmb_pkg, rxmb_if and rxmb_ram.
//
//  Channel | Dir | Payload
//  in_ch   | in  | func, ref_time, mailbox_index, capture_time
//  out_ch  | out | out_mailbox, out_key, batch_count, peak_count, overflowed, last
//
// A start, a dropped load or a load into an empty store completes in the cycle it
// is accepted. Any other load walks down from the top of the row through the
// single RAM read port, with a read state and a write state per slot; the new
// entry lands in slot zero when every held entry moves up. A flush, once accepted,
// emits one transfer per pass through its read and output states while the output
// is taken, since the RAM read is registered.
// Reset clears the counters; the RAM needs no clearing since only entries below
// the count are ever read. A stalled output holds the sequencer, and no input is
// taken until the last result of a flush has been transferred.
`default_nettype none
module rx_mailbox_timestamp_order
    import rxmb_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned TIME_BITS   = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    rxmb_if.sink     in_ch,
    rxmb_if.source   out_ch
);
    localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    // The stored key keeps the wrap bit just above the timer bits.
    localparam int unsigned SKW = TIME_BITS + 1;
    localparam int unsigned EW  = MBOX_BITS + SKW;
    localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(MAX_ENTRIES);

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   peak_reg, peak_next;
    logic                    drop_reg, drop_next;
    logic [TIME_BITS-1:0]    ref_reg, ref_next;
    logic [COUNT_BITS-1:0]   pos_reg, pos_next;   // slot being worked on
    logic [EW-1:0]           new_reg, new_next;   // entry being inserted
    logic                    ovalid_reg, ovalid_next;
    logic [MBOX_BITS-1:0]    omb_reg, omb_next;
    logic [KEY_BITS-1:0]     okey_reg, okey_next;
    logic                    olast_reg, olast_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [EW-1:0]           wr_data, rd_data;

    rxmb_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Key unwrapping of the incoming capture time: a time below the reference
    // gets the wrap bit set, which adds one full timer period.
    logic [TIME_BITS-1:0] cap_t;
    logic [SKW-1:0]       in_key;
    always_comb
    begin
        cap_t  = TIME_BITS'(in_ch.data.capture_time);
        in_key = {(cap_t < ref_reg), cap_t};
    end

    logic [SKW-1:0] rd_key;
    assign rd_key = rd_data[SKW-1:0];

    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (func_t'(in_ch.data.func))
                        FUNC_LOAD:
                        begin
                            if (count_reg != CAP && count_reg != '0)
                            begin
                                state_next = ST_SHIFT_RD;
                            end
                        end
                        FUNC_FLUSH: state_next = (count_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SHIFT_RD: state_next = (pos_reg == '0) ? ST_IDLE : ST_SHIFT_WR;
            ST_SHIFT_WR:
            begin
                if (rd_key <= new_reg[SKW-1:0])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    state_next = (pos_reg + 1'b1 == count_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        peak_next   = peak_reg;
        drop_next   = drop_reg;
        ref_next    = ref_reg;
        pos_next    = pos_reg;
        new_next    = new_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        omb_next    = omb_reg;
        okey_next   = okey_reg;
        olast_next  = olast_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = new_reg;
        rd_addr     = pos_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (func_t'(in_ch.data.func))
                        FUNC_START:
                        begin
                            ref_next   = TIME_BITS'(in_ch.data.ref_time);
                            count_next = '0;
                            drop_next  = 1'b0;
                        end
                        FUNC_LOAD:
                        begin
                            if (count_reg == CAP)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                new_next   = {in_ch.data.mailbox_index, in_key};
                                count_next = count_reg + 1'b1;
                                if (count_reg + 1'b1 > peak_reg)
                                begin
                                    peak_next = count_reg + 1'b1;
                                end
                                pos_next = count_reg;
                                if (count_reg == '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data = {in_ch.data.mailbox_index, in_key};
                                end
                            end
                        end
                        FUNC_FLUSH:
                        begin
                            pos_next = '0;
                            if (count_reg == '0)
                            begin
                                ovalid_next = 1'b1;
                                omb_next    = '0;
                                okey_next   = '0;
                                olast_next  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHIFT_RD:
            begin
                if (pos_reg == '0)
                begin
                    // Every held entry moved up, so the new entry lands in slot zero.
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = new_reg;
                end
                else
                begin
                    rd_addr = AW'(pos_reg - 1'b1);
                end
            end
            ST_SHIFT_WR:
            begin
                // Slot pos is free: either the predecessor moves up or the new entry lands.
                wr_en = 1'b1;
                if (rd_key <= new_reg[SKW-1:0])
                begin
                    wr_data = new_reg;
                end
                else
                begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - 1'b1;
                end
            end
            ST_EMIT_RD: ;
            ST_EMIT_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    omb_next    = rd_data[EW-1:SKW];
                    okey_next   = KEY_BITS'(rd_key);
                    olast_next  = (pos_reg + 1'b1 == count_reg);
                    pos_next    = pos_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            peak_reg   <= '0;
            drop_reg   <= 1'b0;
            ref_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            peak_reg   <= peak_next;
            drop_reg   <= drop_next;
            ref_reg    <= ref_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        new_reg   <= new_next;
        omb_reg   <= omb_next;
        okey_reg  <= okey_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid             = ovalid_reg;
    assign out_ch.data.out_mailbox  = omb_reg;
    assign out_ch.data.out_key      = okey_reg;
    assign out_ch.data.batch_count  = count_reg;
    assign out_ch.data.peak_count   = peak_reg;
    assign out_ch.data.overflowed   = drop_reg;
    assign out_ch.data.last         = olast_reg;
endmodule
`default_nettype wire

[rtl/core/rxmb_checker.sv]
// Port-level checker for the mailbox sorter, bound to the top level.
// Depends on rxmb_pkg.
`default_nettype none
module rxmb_checker
    import rxmb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last,
    input wire logic [COUNT_BITS-1:0] out_batch,
    input wire logic [COUNT_BITS-1:0] out_peak
);
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_peak >= out_batch) else $error("peak below batch");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during emit");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_batch == '0 |-> out_last) else $error("empty not last");
endmodule

bind rx_mailbox_timestamp_order rxmb_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.data.last),
    .out_batch(out_ch.data.batch_count), .out_peak(out_ch.data.peak_count)
);
`default_nettype wire
